FILE: rtl/sk_pkg.sv
// shared constants, types and key normalization for the sorted key table
`timescale 1ns / 1ps

package sk_pkg;

   // table geometry
   localparam int CAPACITY    = 16;
   localparam int KEY_BYTES   = 64;
   localparam int KEY_BITS    = KEY_BYTES * 8;
   localparam int IN_WORDS    = 8;
   localparam int IN_KEY_BITS = IN_WORDS * 64;
   localparam int OCC_W       = $clog2(CAPACITY + 1);

   // port packing
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = ((OP_W + IN_KEY_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((STATUS_W + 1 + COUNT_W + 7) / 8) * 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef logic [KEY_BITS-1:0] key_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_INSERT,
      UPD_DELETE,
      UPD_CLEAR
   } upd_type;

   // command broadcast to every cell
   typedef struct packed {
      logic    compare;
      upd_type upd;
   } cell_cmd_type;

   // per-cell status seen by the controller and the neighbors
   typedef struct packed {
      logic valid;
      logic le;
      logic eq;
   } cell_flag_type;

   // keep the leading bytes up to the first zero byte, zero the rest
   function automatic key_type normalize(input logic [IN_KEY_BITS-1:0] raw);
      key_type              k;
      logic [KEY_BYTES-1:0] nz;
      logic [KEY_BYTES-1:0] low_mask;
      for (int i = 0; i < KEY_BYTES; i++) begin
         nz[i] = |raw[IN_KEY_BITS-1-8*i -: 8];
      end
      for (int i = 0; i < KEY_BYTES; i++) begin
         low_mask = {KEY_BYTES{1'b1}} >> (KEY_BYTES - 1 - i);
         k[KEY_BITS-1-8*i -: 8] = (&(nz | ~low_mask)) ? raw[IN_KEY_BITS-1-8*i -: 8] : 8'h00;
      end
      return k;
   endfunction

endpackage

FILE: rtl/sk_cell.sv
// one table slot: holds a key, compares it with the request key, shifts with neighbors
`timescale 1ns / 1ps

module sk_cell
   import sk_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  key_type       new_key,
   input  key_type       left_key,
   input  logic          left_valid,
   input  logic          left_le,
   input  key_type       right_key,
   input  logic          right_valid,
   output key_type       cell_key,
   output cell_flag_type flag
);

   key_type key_ff, key_in;
   logic    valid_ff, valid_in;
   logic    le_ff, le_in;
   logic    eq_ff, eq_in;

   // compare stored key against the request key
   always_comb begin
      le_in = le_ff;
      eq_in = eq_ff;
      if (cmd.compare) begin
         le_in = valid_ff && (key_ff <= new_key);
         eq_in = valid_ff && (key_ff == new_key);
      end
   end

   // shift rules: insert opens a gap at the first greater slot, delete closes the first match
   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      unique case (cmd.upd)
         UPD_INSERT: begin
            if (!le_ff) begin
               if (!left_le) begin
                  key_in   = left_key;
                  valid_in = left_valid;
               end else begin
                  key_in   = new_key;
                  valid_in = 1'b1;
               end
            end
         end
         UPD_DELETE: begin
            if (valid_ff && (!le_ff || eq_ff)) begin
               key_in   = right_key;
               valid_in = right_valid;
            end
         end
         UPD_CLEAR: begin
            valid_in = 1'b0;
         end
         UPD_NONE: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload and compare flags
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      le_ff  <= le_in;
      eq_ff  <= eq_in;
   end

   assign cell_key   = key_ff;
   assign flag.valid = valid_ff;
   assign flag.le    = le_ff;
   assign flag.eq    = eq_ff;

endmodule

FILE: rtl/sk_ctrl.sv
// operation sequencer, occupancy count and response register
`timescale 1ns / 1ps

module sk_ctrl
   import sk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [OP_W-1:0]       req_op,
   input  cell_flag_type         flags [CAPACITY],
   output cell_cmd_type          cmd,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_found,
   output logic [COUNT_W-1:0]    rsp_count
);

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 found_ff, found_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 accept;
   logic                 out_free;
   logic                 finish;
   logic                 compare_go;
   logic                 match;
   logic                 full;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign full     = (occ_ff == OCC_W'(CAPACITY));

   // any cell holding an equal key
   always_comb begin
      match = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         match = match | flags[i].eq;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_tvalid) state_in = S_COMPARE;
         S_COMPARE: state_in = S_UPDATE;
         S_UPDATE:  if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      compare_go = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         S_IDLE:    req_tready = 1'b1;
         S_COMPARE: compare_go = 1'b1;
         S_UPDATE:  finish     = out_free;
         default:   req_tready = 1'b0;
      endcase
   end

   // table update and result for the finishing word
   always_comb begin
      cmd.compare = compare_go;
      cmd.upd     = UPD_NONE;
      occ_in      = occ_ff;
      status_in   = STATUS_OK;
      found_in    = 1'b0;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               cmd.upd = UPD_INSERT;
               occ_in  = occ_ff + OCC_W'(1);
            end
         end
         OP_DELETE: begin
            if (match) begin
               cmd.upd  = UPD_DELETE;
               occ_in   = occ_ff - OCC_W'(1);
               found_in = 1'b1;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         OP_FIND: begin
            if (match) found_in = 1'b1;
            else       status_in = STATUS_NOT_FOUND;
         end
         OP_CLEAR: begin
            cmd.upd = UPD_CLEAR;
            occ_in  = '0;
         end
         default: begin
         end
      endcase
      if (!finish) begin
         cmd.upd = UPD_NONE;
         occ_in  = occ_ff;
      end
      count_in = COUNT_W'(occ_in);
   end

   // response handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (finish)     rsp_valid_in = 1'b1;
      op_in = accept ? req_op : op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (finish) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_count  = count_ff;

endmodule

FILE: rtl/sorted_key_table_unit.sv
// sorted key table: ordered chain of key cells with insert, delete, find, count, clear
//
//  channel | dir | tdata fields (low bit up)                          | tuser/tlast
//  req_    | in  | op[2:0], key_w0..key_w7 (64 b each), zero pad     | none
//  rsp_    | out | status[1:0], found, entry_count[4:0]              | none
//
// every word passes accept and key normalization, compare in all cells, then
// the shift step that also loads the response register.
// the compare stage is the critical path: a full-width key compare in each cell.
// the next word is accepted while the previous response waits; the shift step
// holds only while the response register is still full.
// synchronous active-high reset empties the table; stored keys are not cleared.
`timescale 1ns / 1ps

module sorted_key_table_unit
   import sk_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // op, key_w0 .. key_w7, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // status, found, entry_count
);

   cell_cmd_type            cmd;
   cell_flag_type           flags [CAPACITY];
   key_type                 cell_key [CAPACITY];
   key_type                 key_ff, key_in;
   logic [IN_KEY_BITS-1:0]  raw_key;
   logic [STATUS_W-1:0]     rsp_status;
   logic                    rsp_found;
   logic [COUNT_W-1:0]      rsp_count;

   // gather key words, byte 0 at the top
   always_comb begin
      for (int w = 0; w < IN_WORDS; w++) begin
         raw_key[IN_KEY_BITS-1-64*w -: 64] = req_tdata[OP_W+64*w +: 64];
      end
   end

   // normalized request key
   assign key_in = (req_tvalid && req_tready) ? normalize(raw_key) : key_ff;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   sk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[OP_W-1:0]),
      .flags      (flags),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_found  (rsp_found),
      .rsp_count  (rsp_count)
   );

   // cell chain, slot 0 holds the smallest key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type left_key, right_key;
      logic    left_valid, left_le, right_valid;
      if (i == 0) begin : g_first
         assign left_key   = '0;
         assign left_valid = 1'b0;
         assign left_le    = 1'b1;
      end else begin : g_mid_l
         assign left_key   = cell_key[i-1];
         assign left_valid = flags[i-1].valid;
         assign left_le    = flags[i-1].le;
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_key   = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_r
         assign right_key   = cell_key[i+1];
         assign right_valid = flags[i+1].valid;
      end
      sk_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_key     (key_ff),
         .left_key    (left_key),
         .left_valid  (left_valid),
         .left_le     (left_le),
         .right_key   (right_key),
         .right_valid (right_valid),
         .cell_key    (cell_key[i]),
         .flag        (flags[i])
      );
   end

   assign rsp_tdata = RSP_TDATA_W'({rsp_count, rsp_found, rsp_status});

endmodule

FILE: rtl/sk_checker.sv
// port-level checks for the sorted key table, bound to the top level
`timescale 1ns / 1ps

module sk_checker
   import sk_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // one word at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous word in flight");

   // count never exceeds the table size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a refused insert only happens on a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == STATUS_FULL |-> rsp_tdata[7:3] == COUNT_W'(CAPACITY))
      else $error("full status with free slots");

   // a match always reports ok
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == STATUS_OK)
      else $error("found with error status");

endmodule

bind sorted_key_table_unit sk_checker u_sk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/sorted_key_table_unit_test.sv
// testbench for the sorted key table: random and directed table operations checked against a model
`timescale 1ns / 1ps

module sorted_key_table_unit_test;
   import sk_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_AT_RSP  = 500;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 20;

   // one predicted response word
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [COUNT_W-1:0]  entry_count;
   } table_result_type;

   // model of the key table and the queue of responses it predicts
   class key_table_scoreboard;
      key_type          stored_keys[$];
      table_result_type predicted[$];
      int               failures;

      function new();
         failures = 0;
      endfunction

      // bytes after the first zero byte count as zero
      function key_type trim_key(key_type raw);
         key_type k;
         bit      ended;
         k     = '0;
         ended = 1'b0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            if (raw[KEY_BITS-1-8*i -: 8] == 8'h00) ended = 1'b1;
            if (!ended) k[KEY_BITS-1-8*i -: 8] = raw[KEY_BITS-1-8*i -: 8];
         end
         return k;
      endfunction

      // apply one accepted request word to the model
      function void note_request(logic [OP_W-1:0] op, key_type raw);
         key_type          k;
         table_result_type res;
         int               pos;
         k           = trim_key(raw);
         res.status  = STATUS_OK;
         res.found   = 1'b0;
         pos         = 0;
         case (op)
            OP_INSERT: begin
               if (stored_keys.size() >= CAPACITY) begin
                  res.status = STATUS_FULL;
               end else begin
                  // after any equal keys
                  while (pos < stored_keys.size() && stored_keys[pos] <= k) pos++;
                  stored_keys.insert(pos, k);
               end
            end
            OP_DELETE: begin
               while (pos < stored_keys.size() && stored_keys[pos] != k) pos++;
               if (pos >= stored_keys.size()) begin
                  res.status = STATUS_NOT_FOUND;
               end else begin
                  res.found = 1'b1;
                  stored_keys.delete(pos);
               end
            end
            OP_FIND: begin
               while (pos < stored_keys.size() && stored_keys[pos] != k) pos++;
               if (pos >= stored_keys.size()) res.status = STATUS_NOT_FOUND;
               else res.found = 1'b1;
            end
            OP_CLEAR: begin
               stored_keys.delete();
            end
            default: ;
         endcase
         res.entry_count = COUNT_W'(stored_keys.size());
         predicted.push_back(res);
      endfunction

      // compare one accepted response word with the oldest prediction
      function void check_response(logic [RSP_TDATA_W-1:0] word);
         table_result_type    want;
         logic [STATUS_W-1:0] got_status;
         logic                got_found;
         logic [COUNT_W-1:0]  got_count;
         got_status = word[STATUS_W-1:0];
         got_found  = word[STATUS_W];
         got_count  = word[STATUS_W+1 +: COUNT_W];
         if (predicted.size() == 0) begin
            $error("response word 0x%0h with no pending prediction", word);
            failures++;
            return;
         end
         want = predicted.pop_front();
         if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            failures++;
         end
         if (got_found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got_found);
            failures++;
         end
         if (got_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, got_count);
            failures++;
         end
      endfunction

      function int pending();
         return predicted.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // op, key_w0 .. key_w7, zero pad
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // status, found, entry_count

   key_table_scoreboard sb;
   key_type             key_pool[16];
   int                  words_sent;

   sorted_key_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // short keys over a small alphabet share prefixes, a few are long or use any byte
   function automatic key_type random_key();
      key_type k;
      int      len;
      k   = '0;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, KEY_BYTES) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 3) == 0) k[KEY_BITS-1-8*i -: 8] = 8'($urandom_range(1, 255));
         else k[KEY_BITS-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 3));
      end
      return k;
   endfunction

   // fill the bytes past the terminator with garbage
   function automatic key_type dress_key(key_type k);
      key_type d;
      int      len;
      d   = k;
      len = KEY_BYTES;
      for (int i = KEY_BYTES - 1; i >= 0; i--) begin
         if (k[KEY_BITS-1-8*i -: 8] == 8'h00) len = i;
      end
      for (int i = len + 1; i < KEY_BYTES; i++) begin
         d[KEY_BITS-1-8*i -: 8] = 8'($urandom_range(0, 255));
      end
      return d;
   endfunction

   function automatic key_type maybe_dress(key_type k);
      return ($urandom_range(0, 1) == 0) ? dress_key(k) : k;
   endfunction

   function automatic key_type noise_key();
      key_type k;
      for (int w = 0; w < KEY_BITS / 32; w++) k[32*w +: 32] = $urandom;
      return k;
   endfunction

   function automatic key_type text_key(string s);
      key_type k;
      k = '0;
      for (int i = 0; i < s.len(); i++) k[KEY_BITS-1-8*i -: 8] = s[i];
      return k;
   endfunction

   // stored key, pool key or fresh key
   function automatic key_type pick_key(int stored_pct, int pool_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < stored_pct && sb.stored_keys.size() > 0)
         return maybe_dress(sb.stored_keys[$urandom_range(0, sb.stored_keys.size() - 1)]);
      if (roll < stored_pct + pool_pct)
         return maybe_dress(key_pool[$urandom_range(0, 15)]);
      return maybe_dress(random_key());
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] pack_request(logic [OP_W-1:0] op, key_type raw);
      logic [REQ_TDATA_W-1:0] d;
      d            = '0;
      d[OP_W-1:0]  = op;
      for (int w = 0; w < IN_WORDS; w++) d[OP_W+64*w +: 64] = raw[KEY_BITS-1-64*w -: 64];
      return d;
   endfunction

   // offer one request word; entered and left at a falling edge
   task automatic send_word(logic [OP_W-1:0] op, key_type raw);
      int gap;
      gap = ((words_sent / 100) % 4 == 1) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = pack_request(op, raw);
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, raw);
      words_sent++;
      @(negedge clock);
   endtask

   // accept response words with random stalls and one long hold-off
   task automatic take_responses();
      int stall;
      int seen;
      seen = 0;
      forever begin
         stall = ((seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 13);
         if (seen == HOLD_AT_RSP) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
         seen++;
         @(negedge clock);
      end
   endtask

   initial begin
      key_type k;
      int      n;
      sb         = new();
      words_sent = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      for (int i = 0; i < 16; i++) key_pool[i] = random_key();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         take_responses();
      join_none

      // directed: empty table, extreme keys, duplicates, normalization, unused codes
      send_word(OP_COUNT, '0);
      send_word(OP_FIND, text_key("alpha"));
      send_word(OP_DELETE, text_key("alpha"));
      send_word(OP_INSERT, '0);
      send_word(OP_INSERT, '1);
      send_word(OP_INSERT, text_key("alpha"));
      send_word(OP_INSERT, dress_key(text_key("alpha")));
      send_word(OP_INSERT, text_key("alp"));
      send_word(OP_INSERT, text_key("alphb"));
      send_word(OP_FIND, dress_key(text_key("alpha")));
      send_word(OP_FIND, text_key("alph"));
      send_word(OP_DELETE, text_key("alpha"));
      send_word(OP_FIND, text_key("alpha"));
      send_word(OP_DELETE, text_key("zzz"));
      send_word(OP_FIND, '1);
      k = noise_key();
      k[KEY_BITS-1 -: 8] = 8'h00;
      send_word(OP_FIND, k);
      send_word(OP_INSERT, {8'h80, {(KEY_BITS-8){1'b0}}});
      send_word(OP_INSERT, {8'h01, {(KEY_BITS-8){1'b0}}});
      send_word(3'd5, noise_key());
      send_word(3'd6, noise_key());
      send_word(3'd7, noise_key());
      send_word(OP_CLEAR, noise_key());
      send_word(OP_COUNT, noise_key());

      // random: runs of fills, probes, drains and mixed noise
      n = words_sent + RANDOM_ITEMS;
      while (words_sent < n) begin
         if ($urandom_range(0, 7) == 0) key_pool[$urandom_range(0, 15)] = random_key();
         case ($urandom_range(0, 3))
            0: repeat ($urandom_range(10, 20)) send_word(OP_INSERT, pick_key(10, 30));
            1: repeat ($urandom_range(10, 20)) begin
               if ($urandom_range(0, 9) < 6) send_word(OP_FIND, pick_key(60, 20));
               else send_word(OP_DELETE, pick_key(60, 20));
            end
            2: repeat ($urandom_range(10, 20)) begin
               if ($urandom_range(0, 3) == 0)
                  send_word(3'($urandom_range(0, 7)), noise_key());
               else
                  send_word(3'($urandom_range(0, 7)), pick_key(40, 30));
            end
            default: begin
               repeat (sb.stored_keys.size() + 2) send_word(OP_DELETE, pick_key(90, 5));
               if ($urandom_range(0, 1) == 0) send_word(OP_CLEAR, pick_key(0, 50));
               send_word(OP_COUNT, pick_key(0, 50));
            end
         endcase
      end
      req_tvalid = 1'b0;

      // let outstanding responses arrive, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/sk_pkg.sv
rtl/sk_cell.sv
rtl/sk_ctrl.sv
rtl/sorted_key_table_unit.sv
rtl/sk_checker.sv
tb/sv/sorted_key_table_unit_test.sv
